>>> hw/rtl/mtd_pkg.sv
package mtd_pkg;

    // receiver mode, one-hot
    typedef enum logic [2:0] {
        MODE_IDLE = 3'b001,
        MODE_RX   = 3'b010,
        MODE_END  = 3'b100
    } mode_t;

    // mode codes as reported on the result word
    localparam logic [1:0] MODE_CODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_CODE_RX   = 2'd1;
    localparam logic [1:0] MODE_CODE_END  = 2'd2;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_HALF_BIT      = 2'd0,
        REG_PREAMBLE      = 2'd1,
        REG_PREAMBLE_TOL  = 2'd2,
        REG_INTERVAL_TOL  = 2'd3
    } reg_index_t;

    // configuration reset values
    localparam logic [15:0] HALF_BIT_RESET     = 16'd500;
    localparam logic [15:0] PREAMBLE_RESET     = 16'd10000;
    localparam logic [15:0] PREAMBLE_TOL_RESET = 16'd2000;
    localparam logic [15:0] INTERVAL_TOL_RESET = 16'd100;

    // one line edge
    typedef struct packed {
        logic        rising_edge;
        logic [15:0] interval_us;
    } edge_t;

    // one result word
    typedef struct packed {
        logic       byte_valid;
        logic [7:0] data_byte;
        logic       pair_error;
        logic       error_sticky;
        logic       end_of_transmission;
        logic [1:0] mode;
    } result_t;

    // configuration write word
    typedef struct packed {
        reg_index_t  reg_index;
        logic [15:0] wdata;
    } cfg_word_t;

    // timing settings as seen by the decode logic
    typedef struct packed {
        logic [16:0] half2_us;
        logic [17:0] half3_us;
        logic [15:0] preamble_time;
        logic [15:0] preamble_tol_us;
        logic [15:0] interval_tol_us;
    } timing_t;

    // absolute difference within tolerance
    function automatic logic near(input logic [17:0] value, input logic [17:0] target,
                                  input logic [15:0] tol);
        logic [17:0] diff;
        diff = (value > target) ? (value - target) : (target - value);
        return diff <= {2'b00, tol};
    endfunction

    // one-hot mode to reported code
    function automatic logic [1:0] mode_code(input mode_t m);
        logic [1:0] code;
        unique case (m)
            MODE_IDLE: code = MODE_CODE_IDLE;
            MODE_RX:   code = MODE_CODE_RX;
            MODE_END:  code = MODE_CODE_END;
            default:   code = MODE_CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

>>> hw/rtl/mtd_chan_if.sv
interface mtd_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

>>> hw/rtl/mtd_step.sv
module mtd_step #(
    parameter int DATA_BITS = 8,
    parameter int SW = 2 * DATA_BITS + 4,
    parameter int CW = $clog2(2 * (DATA_BITS + 1) + 3)
) (
    input  mtd_pkg::mode_t   mode,
    input  logic [SW-1:0]    shift,
    input  logic [CW-1:0]    count,
    input  logic             err,
    input  mtd_pkg::timing_t timing,
    input  mtd_pkg::edge_t   item,
    output mtd_pkg::mode_t   mode_next,
    output logic [SW-1:0]    shift_next,
    output logic [CW-1:0]    count_next,
    output logic             err_next,
    output mtd_pkg::result_t result
);
    import mtd_pkg::*;

    localparam int WINDOW = 2 * (DATA_BITS + 1);
    localparam int DW = 2 * DATA_BITS;
    localparam int NW = (DATA_BITS > 8) ? DATA_BITS : 8;

    logic               smp;
    logic               pre_hit;
    logic               dbl_hit;
    logic               tri_hit;
    logic [SW-1:0]      shift_p;
    logic [CW-1:0]      count_p;
    logic               full;
    logic [CW-1:0]      extra;
    logic [SW-1:0]      aligned;
    logic [DW-1:0]      pairs;
    logic               pair_bad;
    logic [DATA_BITS-1:0] word;
    logic [NW-1:0]      word_wide;
    logic               perr;

    // interval classification
    assign smp     = ~item.rising_edge;
    assign pre_hit = near({2'b00, item.interval_us}, {2'b00, timing.preamble_time},
                          timing.preamble_tol_us);
    assign dbl_hit = near({2'b00, item.interval_us}, {1'b0, timing.half2_us},
                          timing.interval_tol_us);
    assign tri_hit = near({2'b00, item.interval_us}, timing.half3_us,
                          timing.interval_tol_us);

    // append one, two or three half-bit samples
    always_comb
    begin
        priority if (dbl_hit)
        begin
            shift_p = {shift[SW-3:0], smp, smp};
            count_p = count + CW'(2);
        end
        else if (tri_hit)
        begin
            shift_p = {shift[SW-4:0], smp, smp, smp};
            count_p = count + CW'(3);
        end
        else
        begin
            shift_p = {shift[SW-2:0], smp};
            count_p = count + CW'(1);
        end
    end

    // window extraction, dropping the start pair and any overflow samples
    assign full    = (count_p >= CW'(WINDOW));
    assign extra   = count_p - CW'(WINDOW);
    assign aligned = shift_p >> extra;
    assign pairs   = aligned[DW-1:0];

    // manchester pair decode, oldest pair is the msb
    always_comb
    begin
        logic [1:0] pair;
        pair_bad = 1'b0;
        word     = '0;
        for (int k = 0; k < DATA_BITS; k++)
        begin
            pair = pairs[2 * (DATA_BITS - 1 - k) +: 2];
            if (pair == 2'b00 || pair == 2'b11)
            begin
                pair_bad = 1'b1;
            end
            word[DATA_BITS - 1 - k] = pair[1];
        end
    end

    assign word_wide = NW'(word);

    // next state and result word
    always_comb
    begin
        mode_next  = mode;
        shift_next = shift;
        count_next = count;
        err_next   = err;
        perr       = 1'b0;
        result.byte_valid          = 1'b0;
        result.data_byte           = 8'd0;
        result.end_of_transmission = 1'b0;
        unique case (mode)
            MODE_IDLE:
            begin
                if (!item.rising_edge && pre_hit)
                begin
                    shift_next = '0;
                    count_next = '0;
                    mode_next  = MODE_RX;
                end
            end
            MODE_RX:
            begin
                shift_next = shift_p;
                count_next = count_p;
                if (full)
                begin
                    shift_next = '0;
                    count_next = extra;
                    if (pair_bad)
                    begin
                        perr      = 1'b1;
                        err_next  = 1'b1;
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        result.byte_valid = 1'b1;
                        result.data_byte  = word_wide[7:0];
                    end
                end
                if (!perr && count_next == CW'(2) && shift_next[1:0] == 2'b00)
                begin
                    mode_next = MODE_END;
                    result.end_of_transmission = 1'b1;
                end
            end
            MODE_END:
            begin
                mode_next = MODE_IDLE;
            end
            default:
            begin
                mode_next = MODE_IDLE;
            end
        endcase
        result.pair_error   = perr;
        result.error_sticky = err_next;
        result.mode         = mode_code(mode_next);
    end

endmodule

>>> hw/rtl/manchester_edge_timing_decoder.sv
// channel   dir   word        carries
// edges     in    edge_t      line edge: direction, microseconds since previous edge
// results   out   result_t    one result word per edge
// cfg       in    cfg_word_t  register index and write data, always ready
//
// one edge per cycle sustained while results are taken; the result word is registered
// the edge sits in an input register, then one pass of decode logic updates the
// receiver state and loads the result register in the same cycle
// a stalled result holds the decode stage; the input register still takes one edge
// reset clears the receiver state and the pipeline valids and loads the timing defaults
module manchester_edge_timing_decoder #(
    parameter int DATA_BITS = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    mtd_chan_if.sink        edges,
    mtd_chan_if.source      results,
    mtd_chan_if.sink        cfg
);
    import mtd_pkg::*;

    localparam int SW = 2 * DATA_BITS + 4;
    localparam int CW = $clog2(2 * (DATA_BITS + 1) + 3);

    timing_t       timing_reg;
    edge_t         in_reg;
    logic          in_valid_reg;
    result_t       out_reg;
    logic          out_valid_reg;
    mode_t         mode_reg;
    logic [SW-1:0] shift_reg;
    logic [CW-1:0] count_reg;
    logic          err_reg;

    mode_t         mode_next;
    logic [SW-1:0] shift_next;
    logic [CW-1:0] count_next;
    logic          err_next;
    result_t       step_result;
    logic          advance;

    // handshakes
    assign advance       = in_valid_reg && (!out_valid_reg || results.ready);
    assign edges.ready   = !in_valid_reg || advance;
    assign results.valid = out_valid_reg;
    assign results.data  = out_reg;
    assign cfg.ready     = 1'b1;

    // timing registers, multiples of the half bit kept ready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing_reg.half2_us        <= {HALF_BIT_RESET, 1'b0};
            timing_reg.half3_us        <= {1'b0, HALF_BIT_RESET, 1'b0} + {2'b00, HALF_BIT_RESET};
            timing_reg.preamble_time   <= PREAMBLE_RESET;
            timing_reg.preamble_tol_us <= PREAMBLE_TOL_RESET;
            timing_reg.interval_tol_us <= INTERVAL_TOL_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.data.reg_index)
                REG_HALF_BIT:
                begin
                    timing_reg.half2_us <= {cfg.data.wdata, 1'b0};
                    timing_reg.half3_us <= {1'b0, cfg.data.wdata, 1'b0}
                                           + {2'b00, cfg.data.wdata};
                end
                REG_PREAMBLE:     timing_reg.preamble_time   <= cfg.data.wdata;
                REG_PREAMBLE_TOL: timing_reg.preamble_tol_us <= cfg.data.wdata;
                REG_INTERVAL_TOL: timing_reg.interval_tol_us <= cfg.data.wdata;
                default:          timing_reg.preamble_time   <= timing_reg.preamble_time;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (edges.ready)
        begin
            in_valid_reg <= edges.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (edges.valid && edges.ready)
        begin
            in_reg <= edges.data;
        end
    end

    // decode pass
    mtd_step #(
        .DATA_BITS (DATA_BITS),
        .SW        (SW),
        .CW        (CW)
    ) u_step (
        .mode       (mode_reg),
        .shift      (shift_reg),
        .count      (count_reg),
        .err        (err_reg),
        .timing     (timing_reg),
        .item       (in_reg),
        .mode_next  (mode_next),
        .shift_next (shift_next),
        .count_next (count_next),
        .err_next   (err_next),
        .result     (step_result)
    );

    // receiver state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            shift_reg     <= '0;
            count_reg     <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            mode_reg      <= mode_next;
            shift_reg     <= shift_next;
            count_reg     <= count_next;
            err_reg       <= err_next;
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= step_result;
        end
    end

endmodule

>>> hw/rtl/mtd_checker.sv
module mtd_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             res_valid,
    input logic             res_ready,
    input mtd_pkg::result_t res_data
);
    import mtd_pkg::*;

    logic seen_err_reg;
    logic seen_err_next;

    // remember an error reported on any delivered word
    assign seen_err_next = seen_err_reg || (res_valid && res_ready && res_data.error_sticky);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_err_reg <= 1'b0;
        end
        else
        begin
            seen_err_reg <= seen_err_next;
        end
    end

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result word changed while stalled");

    // a bad pair drops back to idle with the error flag set and no byte
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.pair_error |->
            res_data.mode == MODE_CODE_IDLE && res_data.error_sticky && !res_data.byte_valid)
        else $error("pair error with inconsistent result word");

    // end of transmission always reports the end mode
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.end_of_transmission |->
            res_data.mode == MODE_CODE_END && !res_data.pair_error)
        else $error("end of transmission outside end mode");

    // no byte, no data
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.byte_valid |-> res_data.data_byte == 8'd0)
        else $error("data byte without byte valid");

    // error flag never clears once delivered
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && seen_err_reg |-> res_data.error_sticky)
        else $error("error flag cleared");

endmodule

bind manchester_edge_timing_decoder mtd_checker u_mtd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (results.valid),
    .res_ready (results.ready),
    .res_data  (results.data)
);
